// ----- hw/rtl/tdcep_pkg.sv -----
// shared types and constants for the converter edge pairing block
// no dependencies; compiled first
package tdcep_pkg;

    localparam int BOARD_W  = 4;
    localparam int EPOCH_IN_W = 32;
    localparam int EPOCH_W  = 28;
    localparam int CHAN_W   = 7;
    localparam int FINE_W   = 10;
    localparam int COARSE_W = 11;

    // fine code that flags a lost fine time
    localparam logic [FINE_W-1:0] FINE_LOST = 10'h3FF;

    // trigger channel number
    localparam logic [CHAN_W-1:0] TRIG_CHAN = 7'd0;

    typedef struct packed {
        logic                  event_start;
        logic [BOARD_W-1:0]    board_number;
        logic [EPOCH_IN_W-1:0] epoch_value;
        logic [CHAN_W-1:0]     channel_number;
        logic [FINE_W-1:0]     fine_code;
        logic [COARSE_W-1:0]   coarse_time;
        logic                  leading_edge;
    } tdc_word_t;

    typedef struct packed {
        logic                is_trailing_pair;
        logic [BOARD_W-1:0]  out_board;
        logic [CHAN_W-1:0]   out_channel;
        logic [EPOCH_W-1:0]  trigger_epoch;
        logic [COARSE_W-1:0] trigger_coarse;
        logic [FINE_W-1:0]   trigger_fine;
        logic [EPOCH_W-1:0]  lead_epoch;
        logic [COARSE_W-1:0] lead_coarse;
        logic [FINE_W-1:0]   lead_fine;
        logic [EPOCH_W-1:0]  edge_epoch;
        logic [COARSE_W-1:0] edge_coarse;
        logic [FINE_W-1:0]   edge_fine;
    } tdc_rec_t;

endpackage

// ----- hw/rtl/tdcep_if.sv -----
// valid/ready channel interfaces for converter words and pair records
// depends on tdcep_pkg
interface tdcep_word_if import tdcep_pkg::*; ();
    logic      valid;
    logic      ready;
    tdc_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tdcep_rec_if import tdcep_pkg::*; ();
    logic     valid;
    logic     ready;
    tdc_rec_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tdcep_pair_core.sv -----
// per-event state and edge pairing decision for one converter word
// depends on tdcep_pkg
module tdcep_pair_core
    import tdcep_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tdc_word_t word,
    input  logic      fire,
    output logic      has_result,
    output tdc_rec_t  result
);

    typedef struct packed {
        logic [EPOCH_W-1:0]  current_epoch;
        logic [CHAN_W-1:0]   prev_channel;
        logic                lead_pending;
        logic [EPOCH_W-1:0]  pend_epoch;
        logic [COARSE_W-1:0] pend_coarse;
        logic [FINE_W-1:0]   pend_fine;
        logic [EPOCH_W-1:0]  trig_epoch;
        logic [COARSE_W-1:0] trig_coarse;
        logic [FINE_W-1:0]   trig_fine;
    } pair_state_t;

    pair_state_t state_reg;
    pair_state_t state_next;
    pair_state_t base;

    always_comb
    begin
        // event start clears everything before the word is looked at
        base       = word.event_start ? '0 : state_reg;
        state_next = base;
        has_result = 1'b0;
        result     = '0;

        result.out_board      = word.board_number;
        result.out_channel    = word.channel_number;
        result.trigger_epoch  = base.trig_epoch;
        result.trigger_coarse = base.trig_coarse;
        result.trigger_fine   = base.trig_fine;
        result.lead_epoch     = base.pend_epoch;
        result.lead_coarse    = base.pend_coarse;
        result.lead_fine      = base.pend_fine;
        result.edge_epoch     = base.current_epoch;
        result.edge_coarse    = word.coarse_time;
        result.edge_fine      = word.fine_code;

        priority if (word.epoch_value != '0)
        begin
            state_next.current_epoch = word.epoch_value[EPOCH_W-1:0];
        end
        else if (word.fine_code == FINE_LOST)
        begin
            state_next = base;
        end
        else if (word.channel_number < base.prev_channel)
        begin
            state_next = base;
        end
        else
        begin
            state_next.prev_channel = word.channel_number;
            priority if (word.channel_number == TRIG_CHAN)
            begin
                state_next.trig_epoch  = base.current_epoch;
                state_next.trig_coarse = word.coarse_time;
                state_next.trig_fine   = word.fine_code;
            end
            else if (word.leading_edge)
            begin
                state_next.lead_pending = 1'b1;
                state_next.pend_epoch   = base.current_epoch;
                state_next.pend_coarse  = word.coarse_time;
                state_next.pend_fine    = word.fine_code;
                has_result              = 1'b1;
                result.lead_epoch       = base.current_epoch;
                result.lead_coarse      = word.coarse_time;
                result.lead_fine        = word.fine_code;
            end
            else if (base.lead_pending)
            begin
                state_next.lead_pending = 1'b0;
                state_next.pend_epoch   = '0;
                state_next.pend_coarse  = '0;
                state_next.pend_fine    = '0;
                has_result              = 1'b1;
                result.is_trailing_pair = 1'b1;
            end
            else
            begin
                state_next = state_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    a_pair_needs_lead: assert property (@(posedge clk) disable iff (!rst_n)
        has_result && result.is_trailing_pair |-> state_reg.lead_pending && !word.event_start)
        else $error("trailing pair without pending lead");

    a_pair_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
        fire && has_result && result.is_trailing_pair |=> !state_reg.lead_pending)
        else $error("pending lead kept after pairing");

    a_no_trig_record: assert property (@(posedge clk) disable iff (!rst_n)
        has_result |-> word.channel_number != TRIG_CHAN && word.epoch_value == '0)
        else $error("record from trigger or epoch word");

    a_chan_rises: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !word.event_start |=> state_reg.prev_channel >= $past(state_reg.prev_channel))
        else $error("previous channel went down within an event");

endmodule

// ----- hw/rtl/tdc_hit_stream_edge_pairing.sv -----
// top level of the converter word edge pairing block
// depends on tdcep_pkg, tdcep_if and tdcep_pair_core
//
// takes one converter word per cycle on hit and returns at most one edge record
// per word on rec. each word goes through an input register, then a single pass
// of compare and select logic against the per-event state (epoch, last channel,
// trigger time, pending lead), then a result register. throughput is one word
// per clock unless the input stage stalls; the result register drives rec. the
// input stage keeps taking words while a record waits on rec, and only stalls
// when its held word makes a record and the result register is still full.
// epoch words, words with lost fine time, words whose channel drops below the
// last one and trigger-channel words make no record; an event start word clears
// all state first. fine codes are passed on raw, with no calibration
module tdc_hit_stream_edge_pairing
    import tdcep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tdcep_word_if.sink  hit,
    tdcep_rec_if.source rec
);

    // input stage
    logic      s1_valid_reg;
    logic      s1_valid_next;
    tdc_word_t s1_word_reg;

    // result stage
    logic      out_valid_reg;
    logic      out_valid_next;
    tdc_rec_t  out_rec_reg;

    // core decision for the held word
    logic      has_result;
    tdc_rec_t  result;
    logic      out_free;
    logic      s1_fire;
    logic      hit_take;

    tdcep_pair_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (s1_word_reg),
        .fire       (s1_fire),
        .has_result (has_result),
        .result     (result)
    );

    // result register can take a new record this cycle
    assign out_free = !out_valid_reg || rec.ready;

    // held word retires: either it makes no record or the record has a slot
    assign s1_fire = s1_valid_reg && (!has_result || out_free);

    assign hit.ready = !s1_valid_reg || s1_fire;
    assign hit_take  = hit.valid && hit.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (hit.ready)
        begin
            s1_valid_next = hit.valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (s1_fire && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (rec.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (hit_take)
        begin
            s1_word_reg <= hit.data;
        end
        if (s1_fire && has_result)
        begin
            out_rec_reg <= result;
        end
    end

    assign rec.valid = out_valid_reg;
    assign rec.data  = out_rec_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rec.ready |-> !(s1_fire && has_result))
        else $error("pending record overwritten");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |-> has_result && out_valid_reg && !rec.ready)
        else $error("input stage stalled without cause");

    a_rec_held: assert property (@(posedge clk) disable iff (!rst_n)
        rec.valid && !rec.ready |=> rec.valid && $stable(rec.data))
        else $error("waiting record dropped or changed");

endmodule

// ----- tb/sv/tdc_hit_stream_edge_pairing_tb.sv -----
// self-checking testbench for the converter word edge pairing block
// depends on tdcep_pkg, tdcep_if and the tdc_hit_stream_edge_pairing rtl
`timescale 1ns / 1ps

module tdc_hit_stream_edge_pairing_tb;
    import tdcep_pkg::*;

    localparam int WORD_TARGET    = 600;
    // no word or record accepted for this many cycles means the block hung
    localparam int WATCHDOG_LIMIT = 2000;
    // the pipeline registers plus the longest sink stall, with margin
    localparam int TAIL_CYCLES    = 40;

    // one queued converter word; hold_until_empty makes the driver wait for
    // every outstanding record before it offers this word
    typedef struct {
        tdc_word_t word;
        bit        hold_until_empty;
    } queued_word_t;

    logic clk = 1'b0;
    logic rst_n;

    tdcep_word_if hit_if ();
    tdcep_rec_if  rec_if ();

    tdc_hit_stream_edge_pairing dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hit   (hit_if),
        .rec   (rec_if)
    );

    always #4 clk = ~clk;

    queued_word_t word_queue[$];
    tdc_rec_t     rec_expected[$];

    int words_built = 0;
    int words_total = 0;
    int words_taken = 0;
    int err_count   = 0;
    int send_gap    = 0;
    int recv_stall  = 0;
    int idle_cycles = 0;
    bit calm_send   = 1'b0;
    bit calm_recv   = 1'b0;

    // mirror of the per-event state inside the block
    logic [EPOCH_W-1:0]  epoch_now  = '0;
    logic [CHAN_W-1:0]   last_chan  = '0;
    logic                lead_held  = 1'b0;
    logic [EPOCH_W-1:0]  lead_ep    = '0;
    logic [COARSE_W-1:0] lead_co    = '0;
    logic [FINE_W-1:0]   lead_fi    = '0;
    logic [EPOCH_W-1:0]  trig_ep    = '0;
    logic [COARSE_W-1:0] trig_co    = '0;
    logic [FINE_W-1:0]   trig_fi    = '0;

    // ------------------------------------------------------------------
    // edge pairing prediction: updates the mirrored state for one accepted
    // word and queues the record it should produce, if any
    // ------------------------------------------------------------------
    task automatic pair_edges(input tdc_word_t w);
        tdc_rec_t r;
        // event start wipes everything before the word itself is looked at
        if (w.event_start)
        begin
            epoch_now = '0;
            last_chan = '0;
            lead_held = 1'b0;
            lead_ep   = '0;
            lead_co   = '0;
            lead_fi   = '0;
            trig_ep   = '0;
            trig_co   = '0;
            trig_fi   = '0;
        end
        // any nonzero epoch field makes this an epoch word, nothing else counts
        if (w.epoch_value != '0)
        begin
            epoch_now = w.epoch_value[EPOCH_W-1:0];
            return;
        end
        // lost fine time and falling channel are dropped without a trace
        if (w.fine_code == FINE_LOST)
            return;
        if (w.channel_number < last_chan)
            return;
        last_chan = w.channel_number;
        if (w.channel_number == TRIG_CHAN)
        begin
            trig_ep = epoch_now;
            trig_co = w.coarse_time;
            trig_fi = w.fine_code;
            return;
        end
        if (w.leading_edge)
        begin
            // a second lead simply replaces the first one
            lead_held = 1'b1;
            lead_ep   = epoch_now;
            lead_co   = w.coarse_time;
            lead_fi   = w.fine_code;
        end
        else if (!lead_held)
            return;
        r.is_trailing_pair = !w.leading_edge;
        r.out_board        = w.board_number;
        r.out_channel      = w.channel_number;
        r.trigger_epoch    = trig_ep;
        r.trigger_coarse   = trig_co;
        r.trigger_fine     = trig_fi;
        r.lead_epoch       = lead_ep;
        r.lead_coarse      = lead_co;
        r.lead_fine        = lead_fi;
        r.edge_epoch       = epoch_now;
        r.edge_coarse      = w.coarse_time;
        r.edge_fine        = w.fine_code;
        rec_expected.push_back(r);
        // a trail closes the pending lead, which may come from a lower channel
        if (!w.leading_edge)
        begin
            lead_held = 1'b0;
            lead_ep   = '0;
            lead_co   = '0;
            lead_fi   = '0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endtask

    task automatic check_record(input tdc_rec_t got);
        tdc_rec_t want;
        if (rec_expected.size() == 0)
        begin
            report_mismatch($sformatf("record on channel %0d with none outstanding",
                                      got.out_channel));
            return;
        end
        want = rec_expected.pop_front();
        compare_field("is_trailing_pair", 32'(want.is_trailing_pair),
                      32'(got.is_trailing_pair));
        compare_field("out_board", 32'(want.out_board), 32'(got.out_board));
        compare_field("out_channel", 32'(want.out_channel), 32'(got.out_channel));
        compare_field("trigger_epoch", 32'(want.trigger_epoch), 32'(got.trigger_epoch));
        compare_field("trigger_coarse", 32'(want.trigger_coarse), 32'(got.trigger_coarse));
        compare_field("trigger_fine", 32'(want.trigger_fine), 32'(got.trigger_fine));
        compare_field("lead_epoch", 32'(want.lead_epoch), 32'(got.lead_epoch));
        compare_field("lead_coarse", 32'(want.lead_coarse), 32'(got.lead_coarse));
        compare_field("lead_fine", 32'(want.lead_fine), 32'(got.lead_fine));
        compare_field("edge_epoch", 32'(want.edge_epoch), 32'(got.edge_epoch));
        compare_field("edge_coarse", 32'(want.edge_coarse), 32'(got.edge_coarse));
        compare_field("edge_fine", 32'(want.edge_fine), 32'(got.edge_fine));
    endtask

    // idle cycles before the next word or record; calm stretches run flat out
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    task automatic add_word(input bit es, input logic [BOARD_W-1:0] bd,
                            input logic [EPOCH_IN_W-1:0] ep, input logic [CHAN_W-1:0] ch,
                            input logic [FINE_W-1:0] fi, input logic [COARSE_W-1:0] co,
                            input bit ld, input bit hold);
        queued_word_t q;
        q.word.event_start    = es;
        q.word.board_number   = bd;
        q.word.epoch_value    = ep;
        q.word.channel_number = ch;
        q.word.fine_code      = fi;
        q.word.coarse_time    = co;
        q.word.leading_edge   = ld;
        q.hold_until_empty    = hold;
        word_queue.push_back(q);
        if (fi != FINE_LOST)
            words_built++;
    endtask

    // one board event: start word, optional trigger, rising channels carrying
    // lead/trail pairs, with epoch updates and some malformed words mixed in
    task automatic build_event(input bit hold);
        logic [BOARD_W-1:0]    bd;
        logic [EPOCH_IN_W-1:0] ep;
        int                    ch;
        int                    hits;
        bd = BOARD_W'($urandom_range(0, 15));
        ep = $urandom;
        if (ep == '0)
            ep = 32'h1000_0000;
        case ($urandom_range(0, 9))
            0:       add_word(1'($urandom_range(0, 1)), BOARD_W'($urandom), $urandom,
                              CHAN_W'($urandom), FINE_W'($urandom), COARSE_W'($urandom),
                              1'($urandom_range(0, 1)), hold);
            1, 2:    add_word(1'b1, bd, '0, TRIG_CHAN, FINE_W'($urandom_range(0, 1022)),
                              COARSE_W'($urandom_range(0, 2047)),
                              1'($urandom_range(0, 1)), hold);
            default: add_word(1'b1, bd, ep, CHAN_W'($urandom), FINE_W'($urandom),
                              COARSE_W'($urandom), 1'($urandom_range(0, 1)), hold);
        endcase
        if ($urandom_range(0, 3) != 0)
            add_word(1'b0, bd, '0, TRIG_CHAN, FINE_W'($urandom_range(0, 1022)),
                     COARSE_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)), 1'b0);
        ch = 0;
        hits = $urandom_range(1, 6);
        repeat (hits)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                ep = $urandom;
                if (ep == '0)
                    ep = 32'hF000_0000;
                add_word(1'b0, bd, ep, CHAN_W'($urandom), FINE_W'($urandom),
                         COARSE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0);
            end
            ch = ch + $urandom_range(1, 10);
            if (ch > 127)
                ch = 127;
            add_word(1'b0, bd, '0, CHAN_W'(ch), FINE_W'($urandom_range(0, 1022)),
                     COARSE_W'($urandom_range(0, 2047)), 1'b1, 1'b0);
            case ($urandom_range(0, 9))
                0: add_word(1'b0, bd, '0, CHAN_W'(ch), FINE_W'($urandom_range(0, 1022)),
                            COARSE_W'($urandom_range(0, 2047)), 1'b1, 1'b0);
                1: add_word(1'b0, bd, '0, CHAN_W'($urandom), FINE_LOST,
                            COARSE_W'($urandom_range(0, 2047)),
                            1'($urandom_range(0, 1)), 1'b0);
                2: add_word(1'b0, bd, '0, CHAN_W'($urandom_range(0, ch - 1)),
                            FINE_W'($urandom_range(0, 1022)),
                            COARSE_W'($urandom_range(0, 2047)),
                            1'($urandom_range(0, 1)), 1'b0);
                3: ; // lead stays pending, a later trail may close it
                default: add_word(1'b0, bd, '0, CHAN_W'(ch),
                                  FINE_W'($urandom_range(0, 1022)),
                                  COARSE_W'($urandom_range(0, 2047)), 1'b0, 1'b0);
            endcase
            // extra trail on the same channel; it pairs only if a lead is still pending
            if ($urandom_range(0, 7) == 0)
                add_word(1'b0, bd, '0, CHAN_W'(ch), FINE_W'($urandom_range(0, 1022)),
                         COARSE_W'($urandom_range(0, 2047)), 1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued words, predicts at acceptance, then idles
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_if.valid <= 1'b0;
            hit_if.data  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (hit_if.valid && hit_if.ready)
            begin
                pair_edges(hit_if.data);
                words_taken++;
                send_gap = draw_wait(calm_send);
            end
            // a word on offer stays put until it is taken
            if (!hit_if.valid || hit_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    hit_if.valid <= 1'b0;
                end
                else if (word_queue.size() != 0 &&
                         !(word_queue[0].hold_until_empty && rec_expected.size() != 0))
                begin
                    hit_if.valid <= 1'b1;
                    hit_if.data  <= word_queue[0].word;
                    void'(word_queue.pop_front());
                end
                else
                    hit_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each record taken and stalls ready at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_if.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (rec_if.valid && rec_if.ready)
            begin
                check_record(rec_if.data);
                recv_stall = draw_wait(calm_recv);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                rec_if.ready <= 1'b0;
            end
            else
                rec_if.ready <= 1'b1;
        end
    end

    // watchdog on cycles where neither side moves a word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hit_if.valid && hit_if.ready) || (rec_if.valid && rec_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no traffic for %0d cycles", $realtime, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int ev;
        rst_n = 1'b0;

        // directed words, before any random event
        // trigger at the coarse extreme and the top usable fine code
        add_word(1'b1, 4'd0, 32'h0, TRIG_CHAN, 10'd1022, 11'd2047, 1'b0, 1'b0);
        // all-ones epoch word, only the low 28 bits survive; other fields ignored
        add_word(1'b0, 4'd0, 32'hFFFF_FFFF, 7'd127, FINE_LOST, 11'd2047, 1'b1, 1'b0);
        add_word(1'b0, 4'd15, 32'h0, 7'd1, 10'd0, 11'd0, 1'b1, 1'b0);
        // second lead overwrites the first and still makes a record
        add_word(1'b0, 4'd15, 32'h0, 7'd1, 10'd1022, 11'd2047, 1'b1, 1'b0);
        // trail on a higher channel pairs with the lead from channel 1
        add_word(1'b0, 4'd15, 32'h0, 7'd5, 10'h155, 11'h2AA, 1'b0, 1'b0);
        // unpaired trail
        add_word(1'b0, 4'd15, 32'h0, 7'd5, 10'h2AA, 11'h555, 1'b0, 1'b0);
        // lost fine time on a high channel must not move the channel floor
        add_word(1'b0, 4'd9, 32'h0, 7'd127, FINE_LOST, 11'd2047, 1'b1, 1'b0);
        // channel going down
        add_word(1'b0, 4'd9, 32'h0, 7'd3, 10'd17, 11'd300, 1'b1, 1'b0);
        add_word(1'b0, 4'd9, 32'h0, 7'd5, 10'd12, 11'd40, 1'b1, 1'b0);
        // epoch word whose low 28 bits are zero
        add_word(1'b0, 4'd0, 32'h1000_0000, 7'd0, 10'd0, 11'd0, 1'b0, 1'b0);
        add_word(1'b0, 4'd0, 32'h0, 7'd127, 10'd1022, 11'd2047, 1'b1, 1'b0);
        add_word(1'b0, 4'd0, 32'h1, 7'd0, 10'd0, 11'd0, 1'b0, 1'b0);
        // pair across an epoch change
        add_word(1'b0, 4'd6, 32'h0, 7'd127, 10'd0, 11'd0, 1'b0, 1'b0);
        // trigger channel below the last channel is dropped
        add_word(1'b0, 4'd6, 32'h0, TRIG_CHAN, 10'd100, 11'd100, 1'b1, 1'b0);
        // event start on an epoch word, offered only once the block has drained
        add_word(1'b1, 4'd3, 32'h0ABC_DEF1, 7'd64, 10'd5, 11'd5, 1'b1, 1'b1);
        add_word(1'b0, 4'd3, 32'h0, TRIG_CHAN, 10'd511, 11'd1024, 1'b1, 1'b0);
        add_word(1'b0, 4'd3, 32'h0, 7'd64, 10'd1, 11'd2, 1'b0, 1'b0);
        add_word(1'b0, 4'd3, 32'h0, 7'd64, 10'd3, 11'd4, 1'b1, 1'b0);
        // event start on a trail drops the pending lead, so no record
        add_word(1'b1, 4'd12, 32'h0, 7'd2, 10'd7, 11'd8, 1'b0, 1'b0);
        // event start on a lost fine word still clears the state
        add_word(1'b1, 4'd12, 32'h0, 7'd2, FINE_LOST, 11'd8, 1'b1, 1'b0);
        add_word(1'b0, 4'd12, 32'h0, 7'd1, 10'd9, 11'd10, 1'b1, 1'b0);
        add_word(1'b0, 4'd12, 32'h0, 7'd1, 10'd11, 11'd12, 1'b0, 1'b0);

        // random events; now and then the sender waits for a full drain first
        ev = 0;
        while (words_built < WORD_TARGET)
        begin
            build_event(ev % 8 == 7);
            ev++;
        end
        words_total = word_queue.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken < words_total)
            @(posedge clk);
        while (rec_expected.size() != 0)
            @(posedge clk);
        // give any stray record time to show up
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- tdc_hit_stream_edge_pairing.f -----
hw/rtl/tdcep_pkg.sv
hw/rtl/tdcep_if.sv
hw/rtl/tdcep_pair_core.sv
hw/rtl/tdc_hit_stream_edge_pairing.sv
tb/sv/tdc_hit_stream_edge_pairing_tb.sv
